// ----- hw/rtl/hnca_pkg.sv -----
package hnca_pkg;

    localparam int NOTE_W = 9;
    localparam int KEY_W  = 7;
    localparam int VEL_W  = 7;

    localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
    localparam logic [1:0] FUNC_ALL_OFF  = 2'd2;
    localparam logic [1:0] FUNC_ASSIGN   = 2'd3;

    localparam logic [1:0] REG_INVERSION = 2'd0;
    localparam logic [1:0] REG_VOICING   = 2'd1;
    localparam logic [1:0] REG_MASK      = 2'd2;

    localparam logic [1:0] VOICING_OPEN = 2'd1;
    localparam logic [1:0] VOICING_WIDE = 2'd2;

    localparam logic [NOTE_W-1:0] OCTAVE = NOTE_W'(12);

    typedef struct packed {
        logic note_op;
        logic assign_init;
        logic rot_step;
        logic pal_step;
        logic scan_init;
        logic scan_step;
        logic scan_restart;
        logic emit;
        logic next_voice;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic rot_done;
        logic pal_last;
        logic scan_last;
        logic hit_any;
        logic pass2;
        logic out_taken;
        logic voice_last;
    } status_t;

endpackage

// ----- hw/rtl/held_note_chord_voice_allocator.sv -----
// Note on, note off and all-off requests finish in the accept cycle.
// An assign request is accepted, then rotates the chord (up to 6 rotations), then
// builds MAX_HELD palette entries (skipped when nothing is held), then per voice
// scans the palette (no scan when nothing is held; a second pass once the palette
// is used up), emits the result and waits for out_ready; one voice at a time.
// Throughput: one request at a time; a new request is taken once all voices are sent.
// Reset: held count cleared, remembered notes 69/72/75/78..., config to 0, 1, 3.
module held_note_chord_voice_allocator #(
    parameter int MAX_HELD   = 8,
    parameter int NUM_VOICES = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration writes
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [3:0]                  cfg_data,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [hnca_pkg::KEY_W-1:0]  note_number,
    input  logic [hnca_pkg::VEL_W-1:0]  note_velocity,
    // result channel, one item per voice on assign
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  voice_index,
    output logic [hnca_pkg::NOTE_W-1:0] assigned_note,
    output logic [hnca_pkg::VEL_W-1:0]  assigned_velocity,
    output logic                        voice_active,
    output logic                        last_of_run
);
    import hnca_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Sequence the request: rotate, build palette, scan per voice, hold result.
    hnca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .st       (st),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Hold the note list, configuration, palette and the output register.
    hnca_dp #(
        .MAX_HELD   (MAX_HELD),
        .NUM_VOICES (NUM_VOICES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .st                (st),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .func              (func),
        .note_number       (note_number),
        .note_velocity     (note_velocity),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .voice_index       (voice_index),
        .assigned_note     (assigned_note),
        .assigned_velocity (assigned_velocity),
        .voice_active      (voice_active),
        .last_of_run       (last_of_run)
    );

endmodule

// ----- hw/rtl/hnca_ctrl.sv -----
module hnca_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       func,
    input  hnca_pkg::status_t st,
    output logic             in_ready,
    output hnca_pkg::cmd_t   cmd
);
    import hnca_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ROT   = 7'b0000010,
        S_PAL   = 7'b0000100,
        S_SINIT = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_ASSIGN)
                    begin
                        cmd.assign_init = 1'b1;
                        state_next      = S_ROT;
                    end
                    else
                    begin
                        cmd.note_op = 1'b1;
                    end
                end
            end
            S_ROT:
            begin
                if (st.n_zero)
                    state_next = S_SINIT;
                else if (st.rot_done)
                    state_next = S_PAL;
                else
                    cmd.rot_step = 1'b1;
            end
            S_PAL:
            begin
                cmd.pal_step = 1'b1;
                if (st.pal_last)
                    state_next = S_SINIT;
            end
            S_SINIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = st.n_zero ? S_EMIT : S_SCAN;
            end
            S_SCAN:
            begin
                if (st.scan_last && !st.hit_any && !st.pass2)
                begin
                    cmd.scan_restart = 1'b1;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (st.scan_last)
                        state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (st.out_taken)
                begin
                    if (st.voice_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_voice = 1'b1;
                        state_next     = S_SINIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/hnca_dp.sv -----
module hnca_dp #(
    parameter int MAX_HELD   = 8,
    parameter int NUM_VOICES = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hnca_pkg::cmd_t              cmd,
    output hnca_pkg::status_t           st,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [3:0]                  cfg_data,
    input  logic [1:0]                  func,
    input  logic [hnca_pkg::KEY_W-1:0]  note_number,
    input  logic [hnca_pkg::VEL_W-1:0]  note_velocity,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  voice_index,
    output logic [hnca_pkg::NOTE_W-1:0] assigned_note,
    output logic [hnca_pkg::VEL_W-1:0]  assigned_velocity,
    output logic                        voice_active,
    output logic                        last_of_run
);
    import hnca_pkg::*;

    localparam int IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int CNT_W = $clog2(MAX_HELD + 1);
    localparam int OCT_W = IDX_W + 2;
    localparam int VW    = (NUM_VOICES > 4) ? 3 : 2;
    localparam int DW    = NOTE_W + 1;

    // configuration
    logic [2:0] inv_reg;
    logic [1:0] mode_reg;
    logic [3:0] mask_reg;

    // held list, kept ascending
    logic [KEY_W-1:0] held_reg [MAX_HELD];
    logic [VEL_W-1:0] hvel_reg [MAX_HELD];
    logic [CNT_W-1:0] count_reg;

    // assign working set
    logic [NOTE_W-1:0] chord_reg [MAX_HELD];
    logic [VEL_W-1:0]  cvel_reg  [MAX_HELD];
    logic [NOTE_W-1:0] pal_reg   [MAX_HELD];
    logic [VEL_W-1:0]  pvel_reg  [MAX_HELD];
    logic [MAX_HELD-1:0] claimed_reg;
    logic [NOTE_W-1:0] prev_reg  [NUM_VOICES];
    logic [CNT_W-1:0]  n_reg;
    logic [2:0]        rot_reg;
    logic [IDX_W-1:0]  p_reg;
    logic [IDX_W-1:0]  ci_reg;
    logic [OCT_W-1:0]  oct_reg;
    logic [VW-1:0]     v_reg;
    logic              pass2_reg;
    logic              found_reg;
    logic [DW-1:0]     bd_reg;
    logic [NOTE_W-1:0] best_note_reg;
    logic [VEL_W-1:0]  best_vel_reg;
    logic [IDX_W-1:0]  best_idx_reg;

    logic              out_valid_reg;
    logic [1:0]        out_voice_reg;
    logic [NOTE_W-1:0] out_note_reg;
    logic [VEL_W-1:0]  out_vel_reg;
    logic              out_act_reg;
    logic              out_last_reg;

    // note event decode
    logic [MAX_HELD-1:0] eq_vec, lt_vec, pre_eq;
    logic [CNT_W-1:0]    ins_pos;
    logic                is_dup, do_drop, do_add;

    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < MAX_HELD; i++)
        begin
            eq_vec[i] = (CNT_W'(i) < count_reg) && (held_reg[i] == note_number);
            lt_vec[i] = (CNT_W'(i) < count_reg) && (held_reg[i] < note_number);
            ins_pos   = ins_pos + CNT_W'(lt_vec[i]);
        end
        pre_eq[0] = eq_vec[0];
        for (int i = 1; i < MAX_HELD; i++)
            pre_eq[i] = pre_eq[i-1] | eq_vec[i];
        is_dup  = |eq_vec;
        do_drop = cmd.note_op && is_dup &&
                  ((func == FUNC_NOTE_OFF) ||
                   ((func == FUNC_NOTE_ON) && (note_velocity == '0)));
        do_add  = cmd.note_op && (func == FUNC_NOTE_ON) && (note_velocity != '0) &&
                  !is_dup && (count_reg < CNT_W'(MAX_HELD));
    end

    // palette entry being built
    logic [OCT_W-1:0]  oct_eff;
    logic [NOTE_W-1:0] pal_note;
    logic              ci_wrap;

    always_comb
    begin
        oct_eff = oct_reg;
        if ((mode_reg == VOICING_OPEN) && (ci_reg != '0))
            oct_eff = oct_reg + OCT_W'(1);
        else if (mode_reg == VOICING_WIDE)
            oct_eff = oct_reg + OCT_W'(p_reg >> 1);
        pal_note = chord_reg[ci_reg] + NOTE_W'(OCTAVE * oct_eff);
        ci_wrap  = (CNT_W'(ci_reg) + CNT_W'(1)) == n_reg;
    end

    // scan of one palette entry
    logic [NOTE_W-1:0] prev_note;
    logic [NOTE_W-1:0] gap;
    logic              cand, better;
    logic [2:0]        v_ext;
    logic              act;

    always_comb
    begin
        prev_note = prev_reg[v_reg];
        gap       = (pal_reg[p_reg] > prev_note) ? pal_reg[p_reg] - prev_note
                                                 : prev_note - pal_reg[p_reg];
        cand      = pass2_reg || !claimed_reg[p_reg];
        better    = cand && ({1'b0, gap} < bd_reg);
        v_ext     = 3'(v_reg);
        act       = !v_ext[2] && mask_reg[v_ext[1:0]];
    end

    assign st.n_zero     = (n_reg == '0);
    assign st.rot_done   = (rot_reg == '0) || (n_reg <= CNT_W'(1));
    assign st.pal_last   = (p_reg == IDX_W'(MAX_HELD - 1));
    assign st.scan_last  = (p_reg == IDX_W'(MAX_HELD - 1));
    assign st.hit_any    = found_reg || (!pass2_reg && !claimed_reg[p_reg]);
    assign st.pass2      = pass2_reg;
    assign st.out_taken  = out_valid_reg && out_ready;
    assign st.voice_last = (v_reg == VW'(NUM_VOICES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg       <= 3'd0;
            mode_reg      <= 2'd1;
            mask_reg      <= 4'd3;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int v = 0; v < NUM_VOICES; v++)
                prev_reg[v] <= NOTE_W'(69 + 3 * v);
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_INVERSION: inv_reg  <= cfg_data[2:0];
                    REG_VOICING:   mode_reg <= cfg_data[1:0];
                    REG_MASK:      mask_reg <= cfg_data;
                    default:       ;
                endcase
            end

            if (cmd.note_op && (func == FUNC_ALL_OFF))
                count_reg <= '0;
            else if (do_drop)
                count_reg <= count_reg - CNT_W'(1);
            else if (do_add)
                count_reg <= count_reg + CNT_W'(1);

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.emit && !st.n_zero && act)
                prev_reg[v_reg] <= best_note_reg;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (do_drop)
        begin
            for (int i = 0; i < MAX_HELD - 1; i++)
            begin
                if (pre_eq[i])
                begin
                    held_reg[i] <= held_reg[i+1];
                    hvel_reg[i] <= hvel_reg[i+1];
                end
            end
        end
        else if (do_add)
        begin
            for (int i = 0; i < MAX_HELD; i++)
            begin
                if (CNT_W'(i) == ins_pos)
                begin
                    held_reg[i] <= note_number;
                    hvel_reg[i] <= note_velocity;
                end
                else if ((i > 0) && (CNT_W'(i) > ins_pos))
                begin
                    held_reg[i] <= held_reg[(i > 0) ? i - 1 : 0];
                    hvel_reg[i] <= hvel_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end

        if (cmd.assign_init)
        begin
            for (int i = 0; i < MAX_HELD; i++)
            begin
                chord_reg[i] <= NOTE_W'(held_reg[i]);
                cvel_reg[i]  <= hvel_reg[i];
            end
            n_reg       <= count_reg;
            rot_reg     <= (inv_reg == 3'd0) ? 3'd0 : inv_reg - 3'd1;
            p_reg       <= '0;
            ci_reg      <= '0;
            oct_reg     <= '0;
            v_reg       <= '0;
            claimed_reg <= '0;
        end

        // rotate: lowest note goes to the top, one octave up
        if (cmd.rot_step)
        begin
            for (int j = 0; j < MAX_HELD; j++)
            begin
                if (CNT_W'(j) + CNT_W'(1) == n_reg)
                begin
                    chord_reg[j] <= chord_reg[0] + OCTAVE;
                    cvel_reg[j]  <= cvel_reg[0];
                end
                else if ((j < MAX_HELD - 1) && (CNT_W'(j) + CNT_W'(1) < n_reg))
                begin
                    chord_reg[j] <= chord_reg[(j < MAX_HELD - 1) ? j + 1 : j];
                    cvel_reg[j]  <= cvel_reg[(j < MAX_HELD - 1) ? j + 1 : j];
                end
            end
            rot_reg <= rot_reg - 3'd1;
        end

        if (cmd.pal_step)
        begin
            pal_reg[p_reg]  <= pal_note;
            pvel_reg[p_reg] <= cvel_reg[ci_reg];
            p_reg           <= p_reg + IDX_W'(1);
            if (ci_wrap)
            begin
                ci_reg  <= '0;
                oct_reg <= oct_reg + OCT_W'(1);
            end
            else
            begin
                ci_reg <= ci_reg + IDX_W'(1);
            end
        end

        if (cmd.scan_init)
        begin
            p_reg         <= '0;
            pass2_reg     <= 1'b0;
            found_reg     <= 1'b0;
            bd_reg        <= '1;
            best_note_reg <= '0;
            best_vel_reg  <= '0;
            best_idx_reg  <= '0;
        end

        if (cmd.scan_step)
        begin
            if (better)
            begin
                bd_reg        <= {1'b0, gap};
                best_note_reg <= pal_reg[p_reg];
                best_vel_reg  <= pvel_reg[p_reg];
                best_idx_reg  <= p_reg;
            end
            if (cand && !pass2_reg)
                found_reg <= 1'b1;
            p_reg <= p_reg + IDX_W'(1);
        end

        if (cmd.scan_restart)
        begin
            pass2_reg <= 1'b1;
            p_reg     <= '0;
            bd_reg    <= '1;
        end

        if (cmd.emit)
        begin
            out_voice_reg <= v_ext[1:0];
            out_note_reg  <= st.n_zero ? '0 : best_note_reg;
            out_vel_reg   <= st.n_zero ? '0 : best_vel_reg;
            out_act_reg   <= !st.n_zero && act;
            out_last_reg  <= st.voice_last;
            if (!st.n_zero && found_reg && !pass2_reg)
                claimed_reg[best_idx_reg] <= 1'b1;
        end

        if (cmd.next_voice)
            v_reg <= v_reg + VW'(1);
    end

    assign out_valid         = out_valid_reg;
    assign voice_index       = out_voice_reg;
    assign assigned_note     = out_note_reg;
    assign assigned_velocity = out_vel_reg;
    assign voice_active      = out_act_reg;
    assign last_of_run       = out_last_reg;

endmodule
